>>> design/sha1_pkg.sv
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared types, constants and round functions of the SHA-1 hasher core.
// ----------------------------------------------------------------------------
package sha1_pkg;

    localparam int WORD_W      = 32;
    localparam int CHAIN_WORDS = 5;
    localparam int BLOCK_WORDS = 16;
    localparam int COUNT_W     = 61;
    localparam int ROUND_W     = 7;
    localparam int OIDX_W      = 3;

    localparam logic [ROUND_W-1:0] LAST_ROUND = 7'd79;
    localparam logic [OIDX_W-1:0]  LAST_OIDX  = 3'd4;
    localparam logic [7:0]         PAD_BYTE   = 8'h80;

    localparam logic [WORD_W-1:0] H_INIT [CHAIN_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [WORD_W-1:0] K_00_19 = 32'h5A827999;
    localparam logic [WORD_W-1:0] K_20_39 = 32'h6ED9EBA1;
    localparam logic [WORD_W-1:0] K_40_59 = 32'h8F1BBCDC;
    localparam logic [WORD_W-1:0] K_60_79 = 32'hCA62C1D6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_LEN,
        ST_OUT
    } state_t;

    // Which block of the message the compression unit is working on.
    typedef enum logic [1:0] {
        PH_DATA,
        PH_PAD1,
        PH_FINAL
    } phase_t;

    typedef struct packed {
        logic byte_wr;     // store the input byte and count it
        logic pad_wr;      // place the pad byte, clear the tail, maybe the length
        logic len_wr;      // clear the block and write the length only
        logic load_vars;   // copy the chaining value into a..e
        logic round_en;    // run one compression round
        logic chain_add;   // fold a..e into the chaining value
        logic out_adv;     // one digest word transferred
        logic restart;     // last digest word gone, start a new message
    } ctl_cmd_t;

    typedef struct packed {
        logic pos_full;    // next byte fills the block
        logic pad_two;     // padding needs a second block
        logic round_last;  // current round is the last one
        logic out_last;    // current digest word is the last one
    } dp_status_t;

    function automatic logic [WORD_W-1:0] rol(input logic [WORD_W-1:0] x,
                                              input int unsigned s);
        rol = (x << s) | (x >> (WORD_W - s));
    endfunction

    // Insert a byte at lane k, keeping earlier lanes and clearing later ones.
    function automatic logic [WORD_W-1:0] put_byte(input logic [WORD_W-1:0] w,
                                                   input logic [1:0] k,
                                                   input logic [7:0] v);
        logic [WORD_W-1:0] r;
        case (k)
            2'd0:    r = {v, 24'h000000};
            2'd1:    r = {w[31:24], v, 16'h0000};
            2'd2:    r = {w[31:16], v, 8'h00};
            default: r = {w[31:8], v};
        endcase
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] round_f(input logic [ROUND_W-1:0] t,
                                                  input logic [WORD_W-1:0] b,
                                                  input logic [WORD_W-1:0] c,
                                                  input logic [WORD_W-1:0] d);
        logic [WORD_W-1:0] r;
        if (t < 7'd20) begin
            r = (b & c) | (~b & d);
        end else if (t < 7'd40) begin
            r = b ^ c ^ d;
        end else if (t < 7'd60) begin
            r = (b & c) | (b & d) | (c & d);
        end else begin
            r = b ^ c ^ d;
        end
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] round_k(input logic [ROUND_W-1:0] t);
        logic [WORD_W-1:0] r;
        if (t < 7'd20) begin
            r = K_00_19;
        end else if (t < 7'd40) begin
            r = K_20_39;
        end else if (t < 7'd60) begin
            r = K_40_59;
        end else begin
            r = K_60_79;
        end
        return r;
    endfunction

endpackage

>>> design/sha1_ctrl.sv
// ----------------------------------------------------------------------------
// sha1_ctrl
// Sequencer of the SHA-1 core: byte intake, padding, compression, readout.
// ----------------------------------------------------------------------------
module sha1_ctrl import sha1_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_has_byte,
    input  logic       s_last,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  dp_status_t status,
    output ctl_cmd_t   cmd
);

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic   last_pend_reg, last_pend_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_DATA;
            last_pend_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            last_pend_reg <= last_pend_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        last_pend_next = last_pend_reg;
        cmd            = '0;
        s_ready        = 1'b0;
        m_valid        = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.byte_wr    = s_has_byte;
                    last_pend_next = s_last;
                    if (s_has_byte && status.pos_full) begin
                        phase_next = PH_DATA;
                        state_next = ST_LOAD;
                    end else if (s_last) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_LOAD: begin
                cmd.load_vars = 1'b1;
                state_next    = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.round_en = 1'b1;
                if (status.round_last) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                cmd.chain_add = 1'b1;
                unique case (phase_reg)
                    PH_DATA:  state_next = last_pend_reg ? ST_PAD : ST_IDLE;
                    PH_PAD1:  state_next = ST_LEN;
                    PH_FINAL: state_next = ST_OUT;
                    default:  state_next = ST_IDLE;
                endcase
            end
            ST_PAD: begin
                cmd.pad_wr = 1'b1;
                phase_next = status.pad_two ? PH_PAD1 : PH_FINAL;
                state_next = ST_LOAD;
            end
            ST_LEN: begin
                cmd.len_wr = 1'b1;
                phase_next = PH_FINAL;
                state_next = ST_LOAD;
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    cmd.out_adv = 1'b1;
                    if (status.out_last) begin
                        cmd.restart = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

>>> design/sha1_dpath.sv
// ----------------------------------------------------------------------------
// sha1_dpath
// Datapath of the SHA-1 core: block buffer, message schedule, round unit,
// chaining value, byte counter and digest readout.
// ----------------------------------------------------------------------------
module sha1_dpath import sha1_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  ctl_cmd_t          cmd,
    input  logic [7:0]        data_byte,
    output dp_status_t        status,
    output logic [WORD_W-1:0] digest_word,
    output logic [OIDX_W-1:0] word_index
);

    logic [WORD_W-1:0]  chain_reg [CHAIN_WORDS];
    logic [WORD_W-1:0]  chain_next [CHAIN_WORDS];
    logic [WORD_W-1:0]  w_reg [BLOCK_WORDS];
    logic [WORD_W-1:0]  w_next [BLOCK_WORDS];
    logic [WORD_W-1:0]  var_reg [CHAIN_WORDS];
    logic [WORD_W-1:0]  var_next [CHAIN_WORDS];
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [ROUND_W-1:0] round_reg, round_next;
    logic [OIDX_W-1:0]  oidx_reg, oidx_next;

    logic [5:0]         pos;
    logic [3:0]         pos_word;
    logic [63:0]        bit_len;
    logic [WORD_W-1:0]  sched_new;
    logic [WORD_W-1:0]  round_tmp;

    assign pos       = count_reg[5:0];
    assign pos_word  = pos[5:2];
    assign bit_len   = {count_reg, 3'b000};
    assign sched_new = rol(w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0], 1);
    assign round_tmp = rol(var_reg[0], 5)
                     + round_f(round_reg, var_reg[1], var_reg[2], var_reg[3])
                     + var_reg[4] + round_k(round_reg) + w_reg[0];

    assign status.pos_full   = (pos == 6'd63);
    assign status.pad_two    = (pos >= 6'd56);
    assign status.round_last = (round_reg == LAST_ROUND);
    assign status.out_last   = (oidx_reg == LAST_OIDX);

    always_comb begin
        w_next = w_reg;
        if (cmd.byte_wr) begin
            w_next[pos_word] = put_byte(w_reg[pos_word], pos[1:0], data_byte);
        end
        if (cmd.pad_wr) begin
            for (int i = 0; i < BLOCK_WORDS; i++) begin
                if (4'(i) > pos_word) begin
                    w_next[i] = '0;
                end
            end
            w_next[pos_word] = put_byte(w_reg[pos_word], pos[1:0], PAD_BYTE);
            if (!status.pad_two) begin
                w_next[14] = bit_len[63:32];
                w_next[15] = bit_len[31:0];
            end
        end
        if (cmd.len_wr) begin
            for (int i = 0; i < BLOCK_WORDS; i++) begin
                w_next[i] = '0;
            end
            w_next[14] = bit_len[63:32];
            w_next[15] = bit_len[31:0];
        end
        if (cmd.round_en) begin
            // The window always holds W[t] .. W[t+15] with W[t] at the head.
            for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                w_next[i] = w_reg[i+1];
            end
            w_next[BLOCK_WORDS-1] = sched_new;
        end
    end

    always_comb begin
        var_next = var_reg;
        if (cmd.load_vars) begin
            var_next = chain_reg;
        end else if (cmd.round_en) begin
            var_next[0] = round_tmp;
            var_next[1] = var_reg[0];
            var_next[2] = rol(var_reg[1], 30);
            var_next[3] = var_reg[2];
            var_next[4] = var_reg[3];
        end
    end

    always_comb begin
        chain_next = chain_reg;
        count_next = count_reg;
        round_next = round_reg;
        oidx_next  = oidx_reg;
        if (cmd.byte_wr) begin
            count_next = count_reg + 61'd1;
        end
        if (cmd.load_vars) begin
            round_next = '0;
        end else if (cmd.round_en) begin
            round_next = round_reg + 7'd1;
        end
        if (cmd.chain_add) begin
            for (int i = 0; i < CHAIN_WORDS; i++) begin
                chain_next[i] = chain_reg[i] + var_reg[i];
            end
        end
        if (cmd.out_adv) begin
            oidx_next = oidx_reg + 3'd1;
        end
        if (cmd.restart) begin
            chain_next = H_INIT;
            count_next = '0;
            oidx_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain_reg <= H_INIT;
            count_reg <= '0;
            round_reg <= '0;
            oidx_reg  <= '0;
        end else begin
            chain_reg <= chain_next;
            count_reg <= count_next;
            round_reg <= round_next;
            oidx_reg  <= oidx_next;
        end
    end

    always_ff @(posedge aclk) begin
        w_reg   <= w_next;
        var_reg <= var_next;
    end

    always_comb begin
        unique case (oidx_reg)
            3'd0:    digest_word = chain_reg[0];
            3'd1:    digest_word = chain_reg[1];
            3'd2:    digest_word = chain_reg[2];
            3'd3:    digest_word = chain_reg[3];
            default: digest_word = chain_reg[4];
        endcase
    end

    assign word_index = oidx_reg;

endmodule

>>> design/sha1_hasher_core.sv
// ----------------------------------------------------------------------------
// sha1_hasher_core
// Streaming SHA-1: one message byte per input transfer, five digest words out.
// ----------------------------------------------------------------------------
// A byte that does not complete a block is taken in the idle state; a byte that
// completes a 64-byte block adds the load, 80 rounds and the chain update.
// A last transfer adds a padding step and the final block; when the length
// needs a block of its own, a length step and one more block follow.
// Then come five output transfers.
// Throughput: one byte per cycle, but the input stalls while a full block is hashed.
// Reset (aresetn low, synchronous) loads the initial hash and clears the count.
// ----------------------------------------------------------------------------
module sha1_hasher_core import sha1_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel: one optional message byte per transfer.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] has_byte
    input  logic        s_tlast,   // last: ends the message
    // Result channel: digest words, h0 first.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
    output logic        m_tlast    // last_word: set on the fifth word
);

    // The controller only talks to the datapath through these two bundles.
    ctl_cmd_t          cmd;
    dp_status_t        status;
    logic [WORD_W-1:0] digest_word;
    logic [OIDX_W-1:0] word_index;

    sha1_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_has_byte (s_tuser),
        .s_last     (s_tlast),
        .s_ready    (s_tready),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .status     (status),
        .cmd        (cmd)
    );

    sha1_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .data_byte   (s_tdata),
        .status      (status),
        .digest_word (digest_word),
        .word_index  (word_index)
    );

    // The digest words come straight from the chaining registers, which hold
    // still while the words are read out, so the payload is stable under stall.
    assign m_tdata = {5'b00000, word_index, digest_word};
    assign m_tlast = status.out_last;

endmodule

>>> design/sha1_checker.sv
// ----------------------------------------------------------------------------
// sha1_checker
// Port-level checks of the SHA-1 hasher core, bound to the top level.
// ----------------------------------------------------------------------------
module sha1_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast
);

    // Input is never taken while digest words are pending.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_tvalid && s_tready))
        else $error("input ready while a digest word is pending");

    // The final flag marks exactly the fifth word.
    a_last_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tdata[34:32] == 3'd4)))
        else $error("last_word does not match word_index");

    // Words of one digest come out back to back in index order.
    a_word_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=>
            (m_tvalid && (m_tdata[34:32] == $past(m_tdata[34:32]) + 3'd1)))
        else $error("digest words out of order");

    // An empty transfer that does not end a message does not stall the input.
    a_empty_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !s_tuser && !s_tlast) |=> s_tready)
        else $error("empty transfer stalled the input");

    // A stalled result keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("result changed under stall");

endmodule

bind sha1_hasher_core sha1_checker u_sha1_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
